[rtl/core/ssdm_pkg.sv]
// shared types and constants of the duplicate-entry merge block
package ssdm_pkg;

    localparam int ROW_W  = 17;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 21;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [CNT_W-1:0] MAX_ENTRIES = CNT_W'(1048576);

    // request type codes
    localparam logic REQ_ENTRY  = 1'b0;
    localparam logic REQ_MARKER = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic [ROW_W-1:0]        row_index;
        logic signed [VAL_W-1:0] value_re;
        logic signed [VAL_W-1:0] value_im;
        logic                    last_of_column;
        logic                    last_of_matrix;
    } req_t;

    typedef struct packed {
        logic                    entry_valid;
        logic [ROW_W-1:0]        row_index_res;
        logic signed [VAL_W-1:0] value_re_res;
        logic signed [VAL_W-1:0] value_im_res;
        logic                    column_end;
        logic [CNT_W-1:0]        column_end_pointer;
        logic [CNT_W-1:0]        merged_total;
        logic                    last;
    } res_t;

    // classified word passed from front to back
    typedef struct packed {
        logic                    entry;
        logic                    merge;
        logic                    flush;
        logic                    closing;
        logic                    matrix_end;
        logic [ROW_W-1:0]        row;
        logic signed [VAL_W-1:0] re;
        logic signed [VAL_W-1:0] im;
    } op_t;

    typedef struct packed {
        logic pend_valid;
        logic phase;
    } back_stat_t;

endpackage

[rtl/core/sorted_sparse_duplicate_merge.sv]
// top level of the duplicate-entry merge for column-sorted sparse matrices
// takes one word per cycle unless the queue is full; the front end compares each
// entry row with the pending row and queues a classified word (up to four) for
// the back end, which sums duplicate values with saturation and sends one result
// word per cycle unless stalled. a word that yields two results (a new row that
// also closes its column) holds the back end, so the sustained rate is set by
// the output side: one result per cycle. no clearing pass after reset. the user
// must write base_index only while the block is idle; it is not enforced.
module sorted_sparse_duplicate_merge import ssdm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_write,
    input  logic cfg_data,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    logic       base_index_reg;
    logic       push;
    op_t        push_op;
    logic       q_full;
    logic       q_empty;
    logic       pop;
    op_t        head_op;
    logic       front_pend_valid;
    back_stat_t back_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_index_reg <= 1'b0;
        else if (cfg_write)
            base_index_reg <= cfg_data;
    end

    ssdm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .push       (push),
        .push_op    (push_op),
        .q_full     (q_full),
        .pend_valid (front_pend_valid)
    );

    ssdm_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (pop),
        .head_op (head_op),
        .empty   (q_empty)
    );

    ssdm_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .base_index (base_index_reg),
        .q_empty    (q_empty),
        .head_op    (head_op),
        .pop        (pop),
        .stat       (back_stat),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    // front and back agree on the pending entry once the queue has drained
    a_pend_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (q_empty && !back_stat.phase) |-> (front_pend_valid == back_stat.pend_valid))
        else $error("front and back disagree on pending entry");

    // the second result of a word follows without a gap
    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.last) |=> res_valid)
        else $error("second result of a word missing");

    // a result that does not close a column always carries an entry
    a_entry_or_close: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.column_end) |-> (res.entry_valid && res.last == !back_stat.phase))
        else $error("empty result without column end");

endmodule

[rtl/core/ssdm_front.sv]
// front end: accepts words, tracks the pending row and classifies each word
module ssdm_front import ssdm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic push,
    output op_t  push_op,
    input  logic q_full,
    output logic pend_valid
);

    logic             pend_valid_reg, pend_valid_next;
    logic [ROW_W-1:0] pend_row_reg, pend_row_next;
    logic             is_entry;
    logic             match;
    logic             closing;

    assign req_stall  = q_full;
    assign push       = req_valid && !q_full;
    assign pend_valid = pend_valid_reg;

    always_comb
    begin
        is_entry = (req.req_type == REQ_ENTRY);
        match    = pend_valid_reg && (pend_row_reg == req.row_index);
        closing  = (req.req_type == REQ_MARKER) || req.last_of_column || req.last_of_matrix;

        push_op.entry      = is_entry;
        push_op.merge      = is_entry && match;
        push_op.flush      = is_entry && pend_valid_reg && !match;
        push_op.closing    = closing;
        push_op.matrix_end = req.last_of_matrix;
        push_op.row        = req.row_index;
        push_op.re         = req.value_re;
        push_op.im         = req.value_im;

        pend_valid_next = pend_valid_reg;
        pend_row_next   = pend_row_reg;
        if (push)
        begin
            if (closing)
            begin
                pend_valid_next = 1'b0;
                pend_row_next   = '0;
            end
            else if (is_entry)
            begin
                pend_valid_next = 1'b1;
                pend_row_next   = req.row_index;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_row_reg   <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            pend_row_reg   <= pend_row_next;
        end
    end

endmodule

[rtl/core/ssdm_queue.sv]
// short queue of classified words between front and back
module ssdm_queue import ssdm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output op_t  head_op,
    output logic empty
);

    op_t               mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign head_op = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/core/ssdm_back.sv]
// back end: merges values, keeps the counters and drives the result register
module ssdm_back import ssdm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       base_index,
    input  logic       q_empty,
    input  op_t        head_op,
    output logic       pop,
    output back_stat_t stat,
    output logic       res_valid,
    input  logic       res_stall,
    output res_t       res
);

    function automatic logic signed [VAL_W-1:0] sat_add(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [VAL_W-1:0] s;
        s = a + b;
        if (a[VAL_W-1] == b[VAL_W-1] && s[VAL_W-1] != a[VAL_W-1])
            s = a[VAL_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        return s;
    endfunction

    function automatic logic [CNT_W-1:0] count_inc(input logic [CNT_W-1:0] c);
        return (c < MAX_ENTRIES) ? c + 1'b1 : MAX_ENTRIES;
    endfunction

    logic                    pend_valid_reg, pend_valid_next;
    logic [ROW_W-1:0]        pend_row_reg, pend_row_next;
    logic signed [VAL_W-1:0] pend_re_reg, pend_re_next;
    logic signed [VAL_W-1:0] pend_im_reg, pend_im_next;
    logic [CNT_W-1:0]        kept_reg, kept_next;
    logic [CNT_W-1:0]        merge_reg, merge_next;
    logic                    phase_reg, phase_next;
    logic                    res_valid_reg, res_valid_next;
    res_t                    res_reg, res_next;

    logic                    slot_free;
    logic                    beat_flush;
    logic                    emit;
    logic                    fire;
    logic                    cur_valid;
    logic [ROW_W-1:0]        cur_row;
    logic signed [VAL_W-1:0] cur_re;
    logic signed [VAL_W-1:0] cur_im;
    logic [CNT_W-1:0]        merge_upd;
    logic [CNT_W-1:0]        kept_upd;

    assign slot_free  = !res_valid_reg || !res_stall;
    assign beat_flush = head_op.flush && !phase_reg;
    assign emit       = beat_flush || head_op.closing;
    assign fire       = !q_empty && (!emit || slot_free);
    assign pop        = fire && !(beat_flush && head_op.closing);

    assign res_valid       = res_valid_reg;
    assign res             = res_reg;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.phase      = phase_reg;

    always_comb
    begin
        // pending entry once this word's merge or load is applied
        cur_valid = pend_valid_reg;
        cur_row   = pend_row_reg;
        cur_re    = pend_re_reg;
        cur_im    = pend_im_reg;
        merge_upd = merge_reg;
        if (!phase_reg && head_op.entry)
        begin
            cur_valid = 1'b1;
            if (head_op.merge)
            begin
                cur_re    = sat_add(pend_re_reg, head_op.re);
                cur_im    = sat_add(pend_im_reg, head_op.im);
                merge_upd = count_inc(merge_reg);
            end
            else
            begin
                cur_row = head_op.row;
                cur_re  = head_op.re;
                cur_im  = head_op.im;
            end
        end
        kept_upd = cur_valid ? count_inc(kept_reg) : kept_reg;

        pend_valid_next = pend_valid_reg;
        pend_row_next   = pend_row_reg;
        pend_re_next    = pend_re_reg;
        pend_im_next    = pend_im_reg;
        kept_next       = kept_reg;
        merge_next      = merge_reg;
        phase_next      = phase_reg;
        res_valid_next  = res_valid_reg && res_stall;
        res_next        = res_reg;

        if (fire)
        begin
            if (beat_flush)
            begin
                // the earlier row is done: send it, then take the new row
                res_valid_next              = 1'b1;
                res_next.entry_valid        = 1'b1;
                res_next.row_index_res      = pend_row_reg;
                res_next.value_re_res       = pend_re_reg;
                res_next.value_im_res       = pend_im_reg;
                res_next.column_end         = 1'b0;
                res_next.column_end_pointer = '0;
                res_next.merged_total       = merge_reg;
                res_next.last               = !head_op.closing;
                kept_next                   = count_inc(kept_reg);
                pend_valid_next             = 1'b1;
                pend_row_next               = head_op.row;
                pend_re_next                = head_op.re;
                pend_im_next                = head_op.im;
                phase_next                  = head_op.closing;
            end
            else if (head_op.closing)
            begin
                res_valid_next              = 1'b1;
                res_next.entry_valid        = cur_valid;
                res_next.row_index_res      = cur_valid ? cur_row : '0;
                res_next.value_re_res       = cur_valid ? cur_re : '0;
                res_next.value_im_res       = cur_valid ? cur_im : '0;
                res_next.column_end         = 1'b1;
                res_next.column_end_pointer = kept_upd + CNT_W'(base_index);
                res_next.merged_total       = merge_upd;
                res_next.last               = 1'b1;
                pend_valid_next             = 1'b0;
                pend_row_next               = '0;
                pend_re_next                = '0;
                pend_im_next                = '0;
                kept_next                   = head_op.matrix_end ? '0 : kept_upd;
                merge_next                  = head_op.matrix_end ? '0 : merge_upd;
                phase_next                  = 1'b0;
            end
            else
            begin
                pend_valid_next = cur_valid;
                pend_row_next   = cur_row;
                pend_re_next    = cur_re;
                pend_im_next    = cur_im;
                merge_next      = merge_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_row_reg   <= '0;
            pend_re_reg    <= '0;
            pend_im_reg    <= '0;
            kept_reg       <= '0;
            merge_reg      <= '0;
            phase_reg      <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            pend_row_reg   <= pend_row_next;
            pend_re_reg    <= pend_re_next;
            pend_im_reg    <= pend_im_next;
            kept_reg       <= kept_next;
            merge_reg      <= merge_next;
            phase_reg      <= phase_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule
